FILE: rtl/svpc_pkg.sv
package svpc_pkg;

    localparam int VOLT_WIDTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // sqrt(3) in Q16.
    localparam int SQRT3_W = 17;
    localparam logic [SQRT3_W-1:0] SQRT3_Q16 = 17'd113512;

    localparam int BUS_VOLTAGE_RESET = 3072;
    localparam int PWM_PERIOD_RESET  = 4250;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_BUS_VOLTAGE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD  = 2'd1;

    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    typedef struct packed {
        logic       valid;
        logic [2:0] sector;
    } t_tag;

endpackage

FILE: rtl/svpc_vector.sv
module svpc_vector #(
    parameter int VOLT_WIDTH  = svpc_pkg::VOLT_WIDTH_DEF,
    parameter int COUNT_WIDTH = svpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req,
    input  logic signed [VOLT_WIDTH-1:0]  i_v_alpha,
    input  logic signed [VOLT_WIDTH-1:0]  i_v_beta,
    input  logic [VOLT_WIDTH-2:0]         i_bus_voltage,
    input  logic [COUNT_WIDTH-1:0]        i_pwm_period,
    output svpc_pkg::t_tag                o_tag,
    output logic [VOLT_WIDTH+17:0]        o_ux,
    output logic [VOLT_WIDTH+17:0]        o_uy,
    output logic [VOLT_WIDTH+18:0]        o_divisor,
    output logic [COUNT_WIDTH+1:0]        o_scale
);
    import svpc_pkg::*;

    localparam int UW = VOLT_WIDTH + 18;
    localparam int DW = UW + 1;
    localparam int SW = VOLT_WIDTH + 20;
    localparam int QW = COUNT_WIDTH + 2;
    localparam int PW = 2 * VOLT_WIDTH + 2;
    localparam int BW = VOLT_WIDTH - 1;

    // Stage 1: squares for the exact sign tests and the sqrt3 / 3x products.
    logic [VOLT_WIDTH-1:0]            mag_a;
    logic [VOLT_WIDTH-1:0]            mag_b;
    logic signed [VOLT_WIDTH+SQRT3_W:0] n_sb;
    logic signed [VOLT_WIDTH+1:0]     n_a3;

    logic                             r_v1_valid;
    logic [2*VOLT_WIDTH-1:0]          r_sq_a;
    logic [2*VOLT_WIDTH-1:0]          r_sq_b;
    logic signed [VOLT_WIDTH+SQRT3_W:0] r_sb;
    logic signed [VOLT_WIDTH+1:0]     r_a3;
    logic                             r_va_pos;
    logic                             r_va_neg;
    logic                             r_vb_pos;
    logic                             r_vb_neg;

    assign mag_a = i_v_alpha[VOLT_WIDTH-1] ? VOLT_WIDTH'(-i_v_alpha) : VOLT_WIDTH'(i_v_alpha);
    assign mag_b = i_v_beta[VOLT_WIDTH-1] ? VOLT_WIDTH'(-i_v_beta) : VOLT_WIDTH'(i_v_beta);
    assign n_sb  = i_v_beta * $signed({1'b0, SQRT3_Q16});
    assign n_a3  = i_v_alpha * 3'sd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1_valid <= 1'b0;
        end else begin
            r_v1_valid <= i_req;
        end
        r_sq_a   <= mag_a * mag_a;
        r_sq_b   <= mag_b * mag_b;
        r_sb     <= n_sb;
        r_a3     <= n_a3;
        r_va_pos <= !i_v_alpha[VOLT_WIDTH-1] && (|i_v_alpha);
        r_va_neg <= i_v_alpha[VOLT_WIDTH-1];
        r_vb_pos <= !i_v_beta[VOLT_WIDTH-1] && (|i_v_beta);
        r_vb_neg <= i_v_beta[VOLT_WIDTH-1];
    end

    // Stage 2: sector code and the two active-vector voltages.
    logic [PW-1:0]        a2;
    logic [PW-1:0]        b2;
    logic                 gt_pos;
    logic                 gt_neg;
    logic [2:0]           n_sector;
    logic signed [SW-1:0] sbs;
    logic signed [SW-1:0] a3s;
    logic signed [SW-1:0] x2;
    logic signed [SW-1:0] y2;
    logic signed [SW-1:0] z2;
    logic signed [SW-1:0] vx;
    logic signed [SW-1:0] vy;
    logic [UW-1:0]        n_ux;
    logic [UW-1:0]        n_uy;

    t_tag                 r_v2_tag;
    logic [UW-1:0]        r_ux;
    logic [UW-1:0]        r_uy;

    always_comb begin
        a2     = PW'({r_sq_a, 1'b0}) + PW'(r_sq_a);
        b2     = PW'(r_sq_b);
        gt_pos = a2 > b2;
        gt_neg = b2 > a2;
        n_sector[0] = r_vb_pos;
        n_sector[1] = r_va_pos ? (!r_vb_pos || gt_pos) : (r_vb_neg && gt_neg);
        n_sector[2] = r_va_neg ? (!r_vb_pos || gt_pos) : (r_vb_neg && gt_neg);

        sbs = SW'(r_sb);
        a3s = SW'(r_a3) <<< 16;
        x2  = sbs <<< 1;
        y2  = a3s + sbs;
        z2  = sbs - a3s;

        case (n_sector)
            SECTOR_1: begin vx = z2;  vy = y2;  end
            SECTOR_2: begin vx = y2;  vy = -x2; end
            SECTOR_3: begin vx = -z2; vy = x2;  end
            SECTOR_4: begin vx = -x2; vy = z2;  end
            SECTOR_5: begin vx = x2;  vy = -y2; end
            SECTOR_6: begin vx = -y2; vy = -z2; end
            default:  begin vx = '0;  vy = '0;  end
        endcase

        // Rounding of sqrt3 can push a boundary time slightly negative.
        n_ux = vx[SW-1] ? '0 : vx[UW-1:0];
        n_uy = vy[SW-1] ? '0 : vy[UW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2_tag.valid <= 1'b0;
        end else begin
            r_v2_tag.valid <= r_v1_valid;
        end
        r_v2_tag.sector <= n_sector;
        r_ux            <= n_ux;
        r_uy            <= n_uy;
    end

    // Stage 3: overmodulation check picks divisor and period scale.
    logic [DW-1:0] sum;
    logic [BW-1:0] bus_nz;
    logic [DW-1:0] lim;
    logic          over;

    t_tag          r_v3_tag;
    logic [UW-1:0] r_ux3;
    logic [UW-1:0] r_uy3;
    logic [DW-1:0] r_divisor;
    logic [QW-1:0] r_scale;

    always_comb begin
        sum    = DW'(r_ux) + DW'(r_uy);
        bus_nz = (i_bus_voltage == '0) ? BW'(1) : i_bus_voltage;
        lim    = DW'(bus_nz) << 17;
        over   = sum > lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3_tag.valid <= 1'b0;
        end else begin
            r_v3_tag.valid <= r_v2_tag.valid;
        end
        r_v3_tag.sector <= r_v2_tag.sector;
        r_ux3           <= r_ux;
        r_uy3           <= r_uy;
        r_divisor       <= over ? sum : (DW'(bus_nz) << 15);
        r_scale         <= over ? {i_pwm_period, 2'b00} : QW'(i_pwm_period);
    end

    assign o_tag     = r_v3_tag;
    assign o_ux      = r_ux3;
    assign o_uy      = r_uy3;
    assign o_divisor = r_divisor;
    assign o_scale   = r_scale;

endmodule

FILE: rtl/svpc_scale.sv
module svpc_scale #(
    parameter int VOLT_WIDTH  = svpc_pkg::VOLT_WIDTH_DEF,
    parameter int COUNT_WIDTH = svpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  svpc_pkg::t_tag         i_tag,
    input  logic [VOLT_WIDTH+17:0] i_ux,
    input  logic [VOLT_WIDTH+17:0] i_uy,
    input  logic [VOLT_WIDTH+18:0] i_divisor,
    input  logic [COUNT_WIDTH+1:0] i_scale,
    output svpc_pkg::t_tag         o_tag,
    output logic [COUNT_WIDTH+1:0] o_tx4,
    output logic [COUNT_WIDTH+1:0] o_ty4
);
    import svpc_pkg::*;

    localparam int UW = VOLT_WIDTH + 18;
    localparam int DW = UW + 1;
    localparam int QW = COUNT_WIDTH + 2;
    localparam int NW = UW + QW;
    localparam int HW = (UW + 1) / 2;
    localparam int LW = UW - HW;

    // Multiply in two halves, then sum the partial products.
    t_tag             r_m1_tag;
    logic [DW-1:0]    r_m1_div;
    logic [HW+QW-1:0] r_pl_x;
    logic [LW+QW-1:0] r_ph_x;
    logic [HW+QW-1:0] r_pl_y;
    logic [LW+QW-1:0] r_ph_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_tag.valid <= 1'b0;
        end else begin
            r_m1_tag.valid <= i_tag.valid;
        end
        r_m1_tag.sector <= i_tag.sector;
        r_m1_div        <= i_divisor;
        r_pl_x          <= i_ux[HW-1:0] * i_scale;
        r_ph_x          <= i_ux[UW-1:HW] * i_scale;
        r_pl_y          <= i_uy[HW-1:0] * i_scale;
        r_ph_y          <= i_uy[UW-1:HW] * i_scale;
    end

    logic [NW-1:0] prod_x;
    logic [NW-1:0] prod_y;

    assign prod_x = NW'(r_pl_x) + (NW'(r_ph_x) << HW);
    assign prod_y = NW'(r_pl_y) + (NW'(r_ph_y) << HW);

    // Restoring division, one quotient bit per stage. The low product bits
    // shift out of r_sh while quotient bits shift in.
    t_tag          r_tag   [QW+1];
    logic [DW-1:0] r_div   [QW+1];
    logic [DW-1:0] r_rem_x [QW+1];
    logic [DW-1:0] r_rem_y [QW+1];
    logic [QW-1:0] r_sh_x  [QW+1];
    logic [QW-1:0] r_sh_y  [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0].valid <= 1'b0;
        end else begin
            r_tag[0].valid <= r_m1_tag.valid;
        end
        r_tag[0].sector <= r_m1_tag.sector;
        r_div[0]        <= r_m1_div;
        r_rem_x[0]      <= DW'(prod_x[NW-1:QW]);
        r_rem_y[0]      <= DW'(prod_y[NW-1:QW]);
        r_sh_x[0]       <= prod_x[QW-1:0];
        r_sh_y[0]       <= prod_y[QW-1:0];
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [DW:0] trial_x;
        logic [DW:0] trial_y;
        logic [DW:0] diff_x;
        logic [DW:0] diff_y;
        logic        ge_x;
        logic        ge_y;

        always_comb begin
            trial_x = {r_rem_x[k], r_sh_x[k][QW-1]};
            trial_y = {r_rem_y[k], r_sh_y[k][QW-1]};
            diff_x  = trial_x - {1'b0, r_div[k]};
            diff_y  = trial_y - {1'b0, r_div[k]};
            ge_x    = trial_x >= {1'b0, r_div[k]};
            ge_y    = trial_y >= {1'b0, r_div[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k+1].valid <= 1'b0;
            end else begin
                r_tag[k+1].valid <= r_tag[k].valid;
            end
            r_tag[k+1].sector <= r_tag[k].sector;
            r_div[k+1]        <= r_div[k];
            r_rem_x[k+1]      <= ge_x ? diff_x[DW-1:0] : trial_x[DW-1:0];
            r_rem_y[k+1]      <= ge_y ? diff_y[DW-1:0] : trial_y[DW-1:0];
            r_sh_x[k+1]       <= {r_sh_x[k][QW-2:0], ge_x};
            r_sh_y[k+1]       <= {r_sh_y[k][QW-2:0], ge_y};
        end
    end

    assign o_tag = r_tag[QW];
    assign o_tx4 = r_sh_x[QW];
    assign o_ty4 = r_sh_y[QW];

endmodule

FILE: rtl/svpc_timing.sv
module svpc_timing #(
    parameter int COUNT_WIDTH = svpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  svpc_pkg::t_tag         i_tag,
    input  logic [COUNT_WIDTH+1:0] i_tx4,
    input  logic [COUNT_WIDTH+1:0] i_ty4,
    input  logic [COUNT_WIDTH-1:0] i_pwm_period,
    output logic                   o_valid,
    output logic [COUNT_WIDTH-1:0] o_compare_a,
    output logic [COUNT_WIDTH-1:0] o_compare_b,
    output logic [COUNT_WIDTH-1:0] o_compare_c,
    output logic [2:0]             o_sector_code
);
    import svpc_pkg::*;

    localparam int TW = COUNT_WIDTH + 4;
    localparam int CW = COUNT_WIDTH;

    // Quarter-zero times in 1/16 counts.
    logic [TW-1:0] p4;
    t_tag          r_e1_tag;
    logic [TW-1:0] r_ta;
    logic [TW-1:0] r_tb;
    logic [TW-1:0] r_tc;

    assign p4 = TW'({i_pwm_period, 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_tag.valid <= 1'b0;
        end else begin
            r_e1_tag.valid <= i_tag.valid;
        end
        r_e1_tag.sector <= i_tag.sector;
        r_ta            <= p4 - TW'(i_tx4) - TW'(i_ty4);
        r_tb            <= p4 + TW'(i_tx4) - TW'(i_ty4);
        r_tc            <= p4 + TW'(i_tx4) + TW'(i_ty4);
    end

    function automatic logic [CW-1:0] round_clamp(
        input logic [TW-1:0] t,
        input logic [CW-1:0] period
    );
        logic [TW:0] biased;
        logic [CW:0] c;
        biased = (TW+1)'(t) + (TW+1)'(8);
        c      = biased[TW:4];
        return (c > {1'b0, period}) ? period : c[CW-1:0];
    endfunction

    logic [CW-1:0] ca;
    logic [CW-1:0] cb;
    logic [CW-1:0] cc;
    logic [CW-1:0] n_a;
    logic [CW-1:0] n_b;
    logic [CW-1:0] n_c;

    always_comb begin
        ca = round_clamp(r_ta, i_pwm_period);
        cb = round_clamp(r_tb, i_pwm_period);
        cc = round_clamp(r_tc, i_pwm_period);
        case (r_e1_tag.sector)
            SECTOR_1: begin n_a = cb; n_b = ca; n_c = cc; end
            SECTOR_2: begin n_a = ca; n_b = cc; n_c = cb; end
            SECTOR_3: begin n_a = ca; n_b = cb; n_c = cc; end
            SECTOR_4: begin n_a = cc; n_b = cb; n_c = ca; end
            SECTOR_5: begin n_a = cc; n_b = ca; n_c = cb; end
            SECTOR_6: begin n_a = cb; n_b = cc; n_c = ca; end
            default:  begin n_a = '0; n_b = '0; n_c = '0; end
        endcase
    end

    logic          r_valid;
    logic [CW-1:0] r_compare_a;
    logic [CW-1:0] r_compare_b;
    logic [CW-1:0] r_compare_c;
    logic [2:0]    r_sector;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_e1_tag.valid;
        end
        r_compare_a <= n_a;
        r_compare_b <= n_b;
        r_compare_c <= n_c;
        r_sector    <= r_e1_tag.sector;
    end

    assign o_valid       = r_valid;
    assign o_compare_a   = r_compare_a;
    assign o_compare_b   = r_compare_b;
    assign o_compare_c   = r_compare_c;
    assign o_sector_code = r_sector;

endmodule

FILE: rtl/space_vector_pwm_compare_top.sv
// A request taken at a clock edge passes through the vector, multiply, divider and
// timing registers before its result strobe shows.
// Throughput: one request per cycle; the divider is unrolled into one stage
// per quotient bit, so that stage count sets the latency. o_busy stays low.
// Reset is synchronous and active low; it clears all valid bits and loads the
// default bus voltage and period. The receiver cannot stall the strobe.
module space_vector_pwm_compare_top #(
    parameter int VOLT_WIDTH  = svpc_pkg::VOLT_WIDTH_DEF,
    parameter int COUNT_WIDTH = svpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [VOLT_WIDTH-1:0]       i_v_alpha,
    input  logic signed [VOLT_WIDTH-1:0]       i_v_beta,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [svpc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [svpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                               o_valid,
    output logic [COUNT_WIDTH-1:0]             o_compare_a,
    output logic [COUNT_WIDTH-1:0]             o_compare_b,
    output logic [COUNT_WIDTH-1:0]             o_compare_c,
    output logic [2:0]                         o_sector_code
);
    import svpc_pkg::*;

    localparam int UW = VOLT_WIDTH + 18;
    localparam int DW = UW + 1;
    localparam int QW = COUNT_WIDTH + 2;

    logic [VOLT_WIDTH-2:0]  r_bus_voltage;
    logic [COUNT_WIDTH-1:0] r_pwm_period;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_voltage <= BUS_VOLTAGE_RESET[VOLT_WIDTH-2:0];
            r_pwm_period  <= PWM_PERIOD_RESET[COUNT_WIDTH-1:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_BUS_VOLTAGE) begin
                r_bus_voltage <= i_cfg_data[VOLT_WIDTH-2:0];
            end else if (i_cfg_index == REG_PWM_PERIOD) begin
                r_pwm_period <= i_cfg_data[COUNT_WIDTH-1:0];
            end
        end
    end

    logic          req;
    t_tag          vec_tag;
    logic [UW-1:0] vec_ux;
    logic [UW-1:0] vec_uy;
    logic [DW-1:0] vec_div;
    logic [QW-1:0] vec_scale;
    t_tag          scl_tag;
    logic [QW-1:0] scl_tx4;
    logic [QW-1:0] scl_ty4;

    assign req = i_start && !o_busy;

    svpc_vector #(
        .VOLT_WIDTH  (VOLT_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_vector (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_v_alpha     (i_v_alpha),
        .i_v_beta      (i_v_beta),
        .i_bus_voltage (r_bus_voltage),
        .i_pwm_period  (r_pwm_period),
        .o_tag         (vec_tag),
        .o_ux          (vec_ux),
        .o_uy          (vec_uy),
        .o_divisor     (vec_div),
        .o_scale       (vec_scale)
    );

    svpc_scale #(
        .VOLT_WIDTH  (VOLT_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (vec_tag),
        .i_ux      (vec_ux),
        .i_uy      (vec_uy),
        .i_divisor (vec_div),
        .i_scale   (vec_scale),
        .o_tag     (scl_tag),
        .o_tx4     (scl_tx4),
        .o_ty4     (scl_ty4)
    );

    svpc_timing #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_timing (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tag         (scl_tag),
        .i_tx4         (scl_tx4),
        .i_ty4         (scl_ty4),
        .i_pwm_period  (r_pwm_period),
        .o_valid       (o_valid),
        .o_compare_a   (o_compare_a),
        .o_compare_b   (o_compare_b),
        .o_compare_c   (o_compare_c),
        .o_sector_code (o_sector_code)
    );

endmodule

FILE: dv/tb.sv
module tb;
    import svpc_pkg::*;

    localparam int PIPE_LATENCY = COUNT_WIDTH_DEF + 9;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd2;

    typedef struct {
        logic [15:0] cmp_a;
        logic [15:0] cmp_b;
        logic [15:0] cmp_c;
        logic [2:0]  sector;
    } compare_t;

    typedef struct {
        logic signed [15:0] va;
        logic signed [15:0] vb;
        bit                 typed;
        compare_t           cmp;
    } vector_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [15:0] i_v_alpha;
    logic signed [15:0] i_v_beta;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic               o_valid;
    logic [15:0]        o_compare_a;
    logic [15:0]        o_compare_b;
    logic [15:0]        o_compare_c;
    logic [2:0]         o_sector_code;

    space_vector_pwm_compare_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_v_alpha(i_v_alpha), .i_v_beta(i_v_beta),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_compare_a(o_compare_a), .o_compare_b(o_compare_b),
        .o_compare_c(o_compare_c), .o_sector_code(o_sector_code)
    );

    // Shadow copy of the block's two registers.
    logic [14:0] bus_reg;
    logic [15:0] period_reg;

    compare_t    compare_q[$];
    vector_row_t typed_q[$];
    int          fail_count;
    int          result_count;
    int          request_count;
    int          sector_hits[8];
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit sqrt3_above(longint a, longint b);
        longint a2;
        longint b2;
        a2 = a * a * 3;
        b2 = b * b;
        if (a > 0) return (b <= 0) || (a2 > b2);
        if (b >= 0) return 1'b0;
        return b2 > a2;
    endfunction

    function automatic logic [15:0] round_clamp(logic [127:0] v16, logic [127:0] per);
        logic [127:0] c;
        c = (v16 + 8) >> 4;
        return (c > per) ? per[15:0] : c[15:0];
    endfunction

    function automatic compare_t svpwm_compare(logic signed [15:0] va_in,
                                               logic signed [15:0] vb_in);
        longint       va, vb, sb, a3, x2, y2, z2, vx, vy;
        logic [127:0] ux, uy, tx4, ty4, ta, tb, tc, per, bus;
        logic [15:0]  ca, cb, cc;
        logic [2:0]   n;
        compare_t     r;
        va = va_in;
        vb = vb_in;
        per = period_reg;
        bus = (bus_reg == 0) ? 1 : bus_reg;
        sb = vb * 113512;
        a3 = va * 3 * 65536;
        x2 = 2 * sb;
        y2 = a3 + sb;
        z2 = sb - a3;
        n = 3'd0;
        if (vb > 0) n[0] = 1'b1;
        if (sqrt3_above(va, vb)) n[1] = 1'b1;
        if (sqrt3_above(-va, vb)) n[2] = 1'b1;
        case (n)
            SECTOR_1: begin vx = z2;  vy = y2;  end
            SECTOR_2: begin vx = y2;  vy = -x2; end
            SECTOR_3: begin vx = -z2; vy = x2;  end
            SECTOR_4: begin vx = -x2; vy = z2;  end
            SECTOR_5: begin vx = x2;  vy = -y2; end
            SECTOR_6: begin vx = -y2; vy = -z2; end
            default: begin vx = 0; vy = 0; end
        endcase
        ux = (vx < 0) ? 0 : vx;
        uy = (vy < 0) ? 0 : vy;
        if (ux + uy > (bus << 17)) begin
            tx4 = ux * per * 4 / (ux + uy);
            ty4 = uy * per * 4 / (ux + uy);
        end else begin
            tx4 = ux * per / (bus << 15);
            ty4 = uy * per / (bus << 15);
        end
        ta = per * 4 - tx4 - ty4;
        tb = ta + 2 * tx4;
        tc = tb + 2 * ty4;
        ca = round_clamp(ta, per);
        cb = round_clamp(tb, per);
        cc = round_clamp(tc, per);
        r.sector = n;
        case (n)
            SECTOR_1: begin r.cmp_a = cb; r.cmp_b = ca; r.cmp_c = cc; end
            SECTOR_2: begin r.cmp_a = ca; r.cmp_b = cc; r.cmp_c = cb; end
            SECTOR_3: begin r.cmp_a = ca; r.cmp_b = cb; r.cmp_c = cc; end
            SECTOR_4: begin r.cmp_a = cc; r.cmp_b = cb; r.cmp_c = ca; end
            SECTOR_5: begin r.cmp_a = cc; r.cmp_b = ca; r.cmp_c = cb; end
            SECTOR_6: begin r.cmp_a = cb; r.cmp_b = cc; r.cmp_c = ca; end
            default: begin r.cmp_a = '0; r.cmp_b = '0; r.cmp_c = '0; end
        endcase
        return r;
    endfunction

    // Everything is sampled on the clock edge from pre-edge values.
    always @(posedge i_clk) begin
        compare_t    want;
        vector_row_t row;
        bit          active;
        if (i_rst_n) begin
            active = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                active = 1'b1;
                if (i_cfg_index == REG_BUS_VOLTAGE) bus_reg <= i_cfg_data[14:0];
                else if (i_cfg_index == REG_PWM_PERIOD) period_reg <= i_cfg_data[15:0];
            end
            if (i_start && !o_busy) begin
                active = 1'b1;
                want = svpwm_compare(i_v_alpha, i_v_beta);
                if (typed_q.size() > 0) begin
                    row = typed_q.pop_front();
                    if (row.typed) want = row.cmp;
                end
                compare_q.push_back(want);
                request_count++;
            end
            if (o_valid) begin
                active = 1'b1;
                result_count++;
                sector_hits[o_sector_code]++;
                if (compare_q.size() == 0) begin
                    $display("%0t: unexpected result a=%0d b=%0d c=%0d n=%0d", $time,
                             o_compare_a, o_compare_b, o_compare_c, o_sector_code);
                    fail_count++;
                end else begin
                    want = compare_q.pop_front();
                    if (o_compare_a !== want.cmp_a) begin
                        $display("%0t: compare_a expected %0d actual %0d", $time,
                                 want.cmp_a, o_compare_a);
                        fail_count++;
                    end
                    if (o_compare_b !== want.cmp_b) begin
                        $display("%0t: compare_b expected %0d actual %0d", $time,
                                 want.cmp_b, o_compare_b);
                        fail_count++;
                    end
                    if (o_compare_c !== want.cmp_c) begin
                        $display("%0t: compare_c expected %0d actual %0d", $time,
                                 want.cmp_c, o_compare_c);
                        fail_count++;
                    end
                    if (o_sector_code !== want.sector) begin
                        $display("%0t: sector_code expected %0d actual %0d", $time,
                                 want.sector, o_sector_code);
                        fail_count++;
                    end
                end
            end
            idle_cycles <= active ? 0 : idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("FAIL space_vector_pwm_compare_top");
                $finish;
            end
        end
    end

    task automatic send_vector(logic signed [15:0] va, logic signed [15:0] vb);
        i_start   <= 1'b1;
        i_v_alpha <= va;
        i_v_beta  <= vb;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic idle_sender(int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start   <= 1'b0;
            i_v_alpha <= 16'($urandom);
            i_v_beta  <= 16'($urandom);
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (compare_q.size() > 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
    endtask

    // Leaves valid high; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] random_vector_part(int scale);
        int v;
        v = $urandom_range(0, 2 * scale) - scale;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic send_random();
        logic signed [15:0] va;
        logic signed [15:0] vb;
        int                 kind;
        int                 scale;
        longint             edge_b;
        kind  = $urandom_range(0, 9);
        scale = (bus_reg < 16) ? 16 : bus_reg;
        if (kind <= 4) begin
            va = 16'($urandom);
            vb = 16'($urandom);
        end else if (kind <= 7) begin
            // Mostly inside the linear region, well below the bus voltage.
            va = random_vector_part(scale / 2);
            vb = random_vector_part(scale / 2);
        end else if (kind == 8) begin
            // On or next to a sector boundary line.
            va = random_vector_part(16000);
            edge_b = (longint'(va) * 113512) >>> 16;
            edge_b = edge_b + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) edge_b = -edge_b;
            if (edge_b > 32767) edge_b = 32767;
            if (edge_b < -32768) edge_b = -32768;
            vb = 16'(edge_b);
        end else begin
            va = $urandom_range(0, 1) ? 16'sh0 : ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
            vb = $urandom_range(0, 1) ? 16'sh0 : random_vector_part(32767);
        end
        send_vector(va, vb);
    endtask

    vector_row_t directed_rows[] = '{
        '{16'sd0,      16'sd0,      1'b1, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd32767,  16'sd0,      1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{-16'sd32768, 16'sd0,      1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd0,      16'sd32767,  1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd0,      -16'sd32768, 1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd32767,  16'sd32767,  1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{-16'sd32768, -16'sd32768, 1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd32767,  -16'sd32768, 1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{-16'sd32768, 16'sd32767,  1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd866,    16'sd500,    1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd0,      16'sd1000,   1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{-16'sd866,   16'sd500,    1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{-16'sd866,   -16'sd500,   1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd0,      -16'sd1000,  1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd866,    -16'sd500,   1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd577,    16'sd999,    1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{-16'sd577,   16'sd1000,   1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd1,      16'sd0,      1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd0,      16'sd1,      1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{-16'sd1,     16'sd0,      1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd0,      -16'sd1,     1'b0, '{16'd0, 16'd0, 16'd0, 3'd0}},
        '{16'sd0,      16'sd0,      1'b1, '{16'd0, 16'd0, 16'd0, 3'd0}}
    };

    int bus_set[6]    = '{256, 32767, 0, 3072, -1, -1};
    int period_set[6] = '{1, 65535, 0, 4250, -1, -1};
    int idle_set[6]   = '{0, 68, 6, 68, 0, 68};

    initial begin
        logic [31:0] data;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_v_alpha   = '0;
        i_v_beta    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        bus_reg     = 15'(BUS_VOLTAGE_RESET);
        period_reg  = 16'(PWM_PERIOD_RESET);
        fail_count  = 0;
        result_count  = 0;
        request_count = 0;
        idle_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows run with the reset values of both registers.
        foreach (directed_rows[k]) typed_q.push_back(directed_rows[k]);
        foreach (directed_rows[k]) send_vector(directed_rows[k].va, directed_rows[k].vb);
        drain_results();

        for (int phase = 0; phase < 6; phase++) begin
            data = $urandom;
            if (bus_set[phase] >= 0) data[14:0] = 15'(bus_set[phase]);
            else data[14:0] = 15'($urandom_range(256, 32767));
            write_reg(REG_BUS_VOLTAGE, data);
            data = $urandom;
            if (period_set[phase] >= 0) data[15:0] = 16'(period_set[phase]);
            write_reg(REG_PWM_PERIOD, data);
            if (phase == 4) write_reg(REG_UNUSED, $urandom);
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < 290; n++) begin
                idle_sender(idle_set[phase]);
                if (phase == 1 && n == 150) drain_results();
                send_random();
            end
            drain_results();
        end

        $display("Sent %0d requests and checked %0d results over 7 register settings;",
                 request_count, result_count);
        $display("sector hits 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", sector_hits[0],
                 sector_hits[1], sector_hits[2], sector_hits[3], sector_hits[4],
                 sector_hits[5], sector_hits[6], sector_hits[7]);
        if (fail_count == 0 && compare_q.size() == 0) begin
            $display("PASS space_vector_pwm_compare_top");
        end else begin
            $display("FAIL space_vector_pwm_compare_top");
        end
        $finish;
    end
endmodule

FILE: space_vector_pwm_compare_top.f
rtl/svpc_pkg.sv
rtl/svpc_vector.sv
rtl/svpc_scale.sv
rtl/svpc_timing.sv
rtl/space_vector_pwm_compare_top.sv
dv/tb.sv
